@@ rtl/core/tlpt_pkg.sv @@
// tlpt_pkg: command and internal operation codes plus fixed port widths
// for the two-level page translated memory core
// no dependencies
package tlpt_pkg;

	localparam int CMD_W     = 2;
	localparam int PROC_ID_W = 2;
	localparam int SLOT_ID_W = 3;
	localparam int KEY_W     = 5;
	localparam int FRAME_W   = 6;
	localparam int VADDR_W   = 20;
	localparam int DATA_W    = 8;

	typedef logic [CMD_W-1:0] cmd_t;

	localparam cmd_t CMD_SEG_SET  = 2'd0;
	localparam cmd_t CMD_PAGE_SET = 2'd1;
	localparam cmd_t CMD_READ     = 2'd2;
	localparam cmd_t CMD_WRITE    = 2'd3;

	// operation as classified by the front end
	localparam int OP_W = 3;
	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_SEG_WR  = 3'd0;
	localparam op_t OP_PAGE_WR = 3'd1;
	localparam op_t OP_READ    = 3'd2;
	localparam op_t OP_WRITE   = 3'd3;
	localparam op_t OP_NOP     = 3'd4;
	localparam op_t OP_FAULT   = 3'd5;

endpackage

@@ rtl/core/tlpt_front.sv @@
// tlpt_front: input register stage that classifies each command and splits
// the virtual address, then hands the entry to the queue
// depends on tlpt_pkg
module tlpt_front #(
	parameter int OFFSET_BITS = 10,
	parameter int PAGE_BITS   = 5,
	parameter int SEG_BITS    = 5,
	parameter int FRAME_BITS  = 6,
	parameter int NUM_PROCS   = 4,
	parameter int SLOTS       = 8,
	parameter int ENT_W       = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clearing,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  tlpt_pkg::cmd_t                 cmd,
	input  logic [tlpt_pkg::PROC_ID_W-1:0] proc_id,
	input  logic [tlpt_pkg::SLOT_ID_W-1:0] seg_slot,
	input  logic [tlpt_pkg::SLOT_ID_W-1:0] page_slot,
	input  logic [tlpt_pkg::KEY_W-1:0]     key_index,
	input  logic [tlpt_pkg::FRAME_W-1:0]   frame,
	input  logic                           entry_valid,
	input  logic [tlpt_pkg::VADDR_W-1:0]   vaddr,
	input  logic [tlpt_pkg::DATA_W-1:0]    write_data,
	output logic                           q_valid,
	input  logic                           q_ready,
	output logic [ENT_W-1:0]               q_data
);
	import tlpt_pkg::*;

	localparam int PROC_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LOW_W  = OFFSET_BITS + PAGE_BITS + SEG_BITS;
	localparam int VX_W   = LOW_W + VADDR_W;

	typedef struct packed {
		op_t                    op;
		logic [PROC_W-1:0]      proc;
		logic [SLOT_W-1:0]      sslot;
		logic [SLOT_W-1:0]      pslot;
		logic [SEG_BITS-1:0]    skey;
		logic [PAGE_BITS-1:0]   pkey;
		logic [FRAME_BITS-1:0]  frame;
		logic                   ev;
		logic [SEG_BITS-1:0]    seg;
		logic [PAGE_BITS-1:0]   page;
		logic [OFFSET_BITS-1:0] off;
		logic [DATA_W-1:0]      wdata;
	} ent_t;

	logic [VX_W-1:0]    vx;
	logic [VADDR_W-1:0] va_high;
	logic               proc_ok;
	logic               sslot_ok;
	logic               pslot_ok;
	ent_t               ent;
	ent_t               ent_s1;
	logic               valid_s1;

	assign vx       = VX_W'(vaddr);
	assign va_high  = vx[VX_W-1:LOW_W];
	assign proc_ok  = 32'(proc_id) < NUM_PROCS;
	assign sslot_ok = 32'(seg_slot) < SLOTS;
	assign pslot_ok = 32'(page_slot) < SLOTS;

	always_comb begin
		ent.proc  = PROC_W'(proc_id);
		ent.sslot = SLOT_W'(seg_slot);
		ent.pslot = SLOT_W'(page_slot);
		ent.skey  = SEG_BITS'(key_index);
		ent.pkey  = PAGE_BITS'(key_index);
		ent.frame = FRAME_BITS'(frame);
		ent.ev    = entry_valid;
		ent.seg   = vx[OFFSET_BITS+PAGE_BITS +: SEG_BITS];
		ent.page  = vx[OFFSET_BITS +: PAGE_BITS];
		ent.off   = vx[OFFSET_BITS-1:0];
		ent.wdata = write_data;
		unique case (cmd) inside
			CMD_SEG_SET: begin
				ent.op = (proc_ok && sslot_ok) ? OP_SEG_WR : OP_NOP;
			end
			CMD_PAGE_SET: begin
				ent.op = (proc_ok && sslot_ok && pslot_ok) ? OP_PAGE_WR : OP_NOP;
			end
			CMD_READ, CMD_WRITE: begin
				// segment bits that do not fit in SEG_BITS can never match
				if (!proc_ok || (va_high != '0)) begin
					ent.op = OP_FAULT;
				end else begin
					ent.op = (cmd == CMD_READ) ? OP_READ : OP_WRITE;
				end
			end
			default: begin
				ent.op = OP_NOP;
			end
		endcase
	end

	assign in_ready = !clearing && (!valid_s1 || q_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (q_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ent_s1 <= ent;
		end
	end

	assign q_valid = valid_s1;
	assign q_data  = ent_s1;

endmodule

@@ rtl/core/tlpt_queue.sv @@
// tlpt_queue: two-entry fifo between front end and back end
// no dependencies
module tlpt_queue #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output logic [W-1:0] rd_data
);
	logic [W-1:0] slot_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   cnt_q;
	logic         push;
	logic         pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = slot_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

endmodule

@@ rtl/core/tlpt_back.sv @@
// tlpt_back: table memories, byte store and the sequencer that walks the
// segment and page tables for each access; also owns the result register
// depends on tlpt_pkg
module tlpt_back #(
	parameter int OFFSET_BITS = 10,
	parameter int PAGE_BITS   = 5,
	parameter int SEG_BITS    = 5,
	parameter int FRAME_BITS  = 6,
	parameter int NUM_PROCS   = 4,
	parameter int SLOTS       = 8,
	parameter int ENT_W       = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	output logic                        clearing,
	input  logic                        q_valid,
	output logic                        q_ready,
	input  logic [ENT_W-1:0]            q_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tlpt_pkg::DATA_W-1:0] read_data,
	output logic                        status
);
	import tlpt_pkg::*;

	localparam int PROC_W    = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PAGE_ROWS = NUM_PROCS * SLOTS;
	localparam int PROW_W    = (PAGE_ROWS > 1) ? $clog2(PAGE_ROWS) : 1;
	localparam int PA_W      = FRAME_BITS + OFFSET_BITS;
	localparam int STORE_D   = 2 ** PA_W;
	localparam int SEG_E_W   = 1 + SEG_BITS;
	localparam int PG_E_W    = 1 + PAGE_BITS + FRAME_BITS;
	localparam int CLR_D0    = (PAGE_ROWS > NUM_PROCS) ? PAGE_ROWS : NUM_PROCS;
	localparam int CLR_DEPTH = (STORE_D > CLR_D0) ? STORE_D : CLR_D0;
	localparam int CLR_W     = $clog2(CLR_DEPTH);
	localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SEG   = 3'd2;
	localparam logic [2:0] ST_PAGE  = 3'd3;
	localparam logic [2:0] ST_DATA  = 3'd4;

	typedef struct packed {
		op_t                    op;
		logic [PROC_W-1:0]      proc;
		logic [SLOT_W-1:0]      sslot;
		logic [SLOT_W-1:0]      pslot;
		logic [SEG_BITS-1:0]    skey;
		logic [PAGE_BITS-1:0]   pkey;
		logic [FRAME_BITS-1:0]  frame;
		logic                   ev;
		logic [SEG_BITS-1:0]    seg;
		logic [PAGE_BITS-1:0]   page;
		logic [OFFSET_BITS-1:0] off;
		logic [DATA_W-1:0]      wdata;
	} ent_t;

	// segment table: one row per process, entry is {valid, key}
	logic [SLOTS-1:0][SEG_E_W-1:0] seg_mem [NUM_PROCS];
	// page table: one row per segment slot, entry is {valid, key, frame}
	logic [SLOTS-1:0][PG_E_W-1:0]  pg_mem [PAGE_ROWS];
	logic [DATA_W-1:0]             byte_mem [STORE_D];

	logic [SLOTS-1:0][SEG_E_W-1:0] seg_rd_q;
	logic [SLOTS-1:0][PG_E_W-1:0]  pg_rd_q;
	logic [DATA_W-1:0]             byte_rd_q;

	logic [2:0]        st_q;
	logic [CLR_W-1:0]  clr_q;
	ent_t              cur_q;
	ent_t              head;
	logic              out_valid_q;
	logic [DATA_W-1:0] rdata_q;
	logic              status_q;
	logic              pop;
	logic              res_done;

	logic               seg_we;
	logic               seg_wall;
	logic [PROC_W-1:0]  seg_waddr;
	logic [SLOT_W-1:0]  seg_wlane;
	logic [SEG_E_W-1:0] seg_wentry;
	logic [PROC_W-1:0]  seg_raddr;

	logic               pg_we;
	logic               pg_wall;
	logic [PROW_W-1:0]  pg_waddr;
	logic [SLOT_W-1:0]  pg_wlane;
	logic [PG_E_W-1:0]  pg_wentry;
	logic [PROW_W-1:0]  pg_raddr;

	logic               byte_we;
	logic [PA_W-1:0]    byte_waddr;
	logic [DATA_W-1:0]  byte_wdata;
	logic [PA_W-1:0]    byte_raddr;

	logic                  seg_hit;
	logic [SLOT_W-1:0]     seg_idx;
	logic                  pg_hit;
	logic [FRAME_BITS-1:0] pg_frame;

	assign head     = q_data;
	assign clearing = (st_q == ST_CLEAR);
	assign pop      = (st_q == ST_IDLE) && q_valid && (!out_valid_q || out_ready);
	assign q_ready  = pop;

	// lowest matching valid segment slot
	always_comb begin
		seg_hit = 1'b0;
		seg_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!seg_hit && seg_rd_q[i][SEG_E_W-1] && (seg_rd_q[i][SEG_BITS-1:0] == cur_q.seg)) begin
				seg_hit = 1'b1;
				seg_idx = SLOT_W'(i);
			end
		end
	end

	// lowest matching valid page entry
	always_comb begin
		pg_hit   = 1'b0;
		pg_frame = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!pg_hit && pg_rd_q[i][PG_E_W-1] &&
			    (pg_rd_q[i][FRAME_BITS +: PAGE_BITS] == cur_q.page)) begin
				pg_hit   = 1'b1;
				pg_frame = pg_rd_q[i][FRAME_BITS-1:0];
			end
		end
	end

	assign seg_raddr  = head.proc;
	assign pg_raddr   = PROW_W'(32'(cur_q.proc) * SLOTS + 32'(seg_idx));
	assign byte_raddr = {pg_frame, cur_q.off};

	always_comb begin
		seg_we     = 1'b0;
		seg_wall   = 1'b0;
		seg_waddr  = head.proc;
		seg_wlane  = head.sslot;
		seg_wentry = {head.ev, head.skey};
		pg_we      = 1'b0;
		pg_wall    = 1'b0;
		pg_waddr   = PROW_W'(32'(head.proc) * SLOTS + 32'(head.sslot));
		pg_wlane   = head.pslot;
		pg_wentry  = {head.ev, head.pkey, head.frame};
		byte_we    = 1'b0;
		byte_waddr = byte_raddr;
		byte_wdata = cur_q.wdata;
		unique case (st_q)
			ST_CLEAR: begin
				seg_we     = 32'(clr_q) < NUM_PROCS;
				seg_wall   = 1'b1;
				seg_waddr  = clr_q[PROC_W-1:0];
				pg_we      = 32'(clr_q) < PAGE_ROWS;
				pg_wall    = 1'b1;
				pg_waddr   = clr_q[PROW_W-1:0];
				byte_we    = 32'(clr_q) < STORE_D;
				byte_waddr = clr_q[PA_W-1:0];
				byte_wdata = '0;
			end
			ST_IDLE: begin
				seg_we = pop && (head.op == OP_SEG_WR);
				pg_we  = pop && (head.op == OP_PAGE_WR);
			end
			ST_PAGE: begin
				byte_we = pg_hit && (cur_q.op == OP_WRITE);
			end
			ST_SEG, ST_DATA: begin
			end
			default: begin
			end
		endcase
	end

	// the transaction in flight finishes and its result is loaded
	always_comb begin
		res_done = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				res_done = pop && !(head.op inside {OP_READ, OP_WRITE});
			end
			ST_SEG: begin
				res_done = !seg_hit;
			end
			ST_PAGE: begin
				res_done = !(pg_hit && (cur_q.op == OP_READ));
			end
			ST_DATA: begin
				res_done = 1'b1;
			end
			ST_CLEAR: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (seg_we) begin
			if (seg_wall) begin
				seg_mem[seg_waddr] <= '0;
			end else begin
				seg_mem[seg_waddr][seg_wlane] <= seg_wentry;
			end
		end
		seg_rd_q <= seg_mem[seg_raddr];
	end

	always_ff @(posedge clk) begin
		if (pg_we) begin
			if (pg_wall) begin
				pg_mem[pg_waddr] <= '0;
			end else begin
				pg_mem[pg_waddr][pg_wlane] <= pg_wentry;
			end
		end
		pg_rd_q <= pg_mem[pg_raddr];
	end

	always_ff @(posedge clk) begin
		if (byte_we) begin
			byte_mem[byte_waddr] <= byte_wdata;
		end
		byte_rd_q <= byte_mem[byte_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == CLR_LAST) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop && (head.op inside {OP_READ, OP_WRITE})) begin
						st_q <= ST_SEG;
					end
				end
				ST_SEG: begin
					if (seg_hit) begin
						st_q <= ST_PAGE;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_PAGE: begin
					if (pg_hit && (cur_q.op == OP_READ)) begin
						st_q <= ST_DATA;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_DATA: begin
					st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload, loaded together with out_valid_q
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q    <= head;
			rdata_q  <= '0;
			status_q <= (head.op == OP_FAULT);
		end
		if ((st_q == ST_SEG) && !seg_hit) begin
			status_q <= 1'b1;
		end
		if ((st_q == ST_PAGE) && !pg_hit) begin
			status_q <= 1'b1;
		end
		if (st_q == ST_DATA) begin
			rdata_q <= byte_rd_q;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = rdata_q;
	assign status    = status_q;

endmodule

@@ rtl/core/two_level_page_translate_mem_core.sv @@
// path from input acceptance to out_valid: register stage, queue, then back end walk
// the back end sequencer takes a new command only when idle, so each access finishes
// before the next: segment row read, page row read, then byte store read, each registered
// after reset the tables and byte store are cleared with in_ready low; the clear counter
// walks max(2^(FRAME_BITS+OFFSET_BITS), NUM_PROCS*SLOTS) addresses (65536 at defaults)
module two_level_page_translate_mem_core #(
	parameter int OFFSET_BITS = 10,
	parameter int PAGE_BITS   = 5,
	parameter int SEG_BITS    = 5,
	parameter int FRAME_BITS  = 6,
	parameter int NUM_PROCS   = 4,
	parameter int SLOTS       = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  tlpt_pkg::cmd_t                 cmd,
	input  logic [tlpt_pkg::PROC_ID_W-1:0] proc_id,
	input  logic [tlpt_pkg::SLOT_ID_W-1:0] seg_slot,
	input  logic [tlpt_pkg::SLOT_ID_W-1:0] page_slot,
	input  logic [tlpt_pkg::KEY_W-1:0]     key_index,
	input  logic [tlpt_pkg::FRAME_W-1:0]   frame,
	input  logic                           entry_valid,
	input  logic [tlpt_pkg::VADDR_W-1:0]   vaddr,
	input  logic [tlpt_pkg::DATA_W-1:0]    write_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tlpt_pkg::DATA_W-1:0]    read_data,
	output logic                           status
);
	import tlpt_pkg::*;

	localparam int PROC_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ENT_W  = OP_W + PROC_W + 2 * SLOT_W + 2 * SEG_BITS + 2 * PAGE_BITS
	                        + FRAME_BITS + 1 + OFFSET_BITS + DATA_W;

	logic             clearing;
	logic             fq_valid;
	logic             fq_ready;
	logic [ENT_W-1:0] fq_data;
	logic             qb_valid;
	logic             qb_ready;
	logic [ENT_W-1:0] qb_data;

	tlpt_front #(
		.OFFSET_BITS (OFFSET_BITS),
		.PAGE_BITS   (PAGE_BITS),
		.SEG_BITS    (SEG_BITS),
		.FRAME_BITS  (FRAME_BITS),
		.NUM_PROCS   (NUM_PROCS),
		.SLOTS       (SLOTS),
		.ENT_W       (ENT_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.clearing    (clearing),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.proc_id     (proc_id),
		.seg_slot    (seg_slot),
		.page_slot   (page_slot),
		.key_index   (key_index),
		.frame       (frame),
		.entry_valid (entry_valid),
		.vaddr       (vaddr),
		.write_data  (write_data),
		.q_valid     (fq_valid),
		.q_ready     (fq_ready),
		.q_data      (fq_data)
	);

	tlpt_queue #(
		.W (ENT_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_data  (fq_data),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_data  (qb_data)
	);

	tlpt_back #(
		.OFFSET_BITS (OFFSET_BITS),
		.PAGE_BITS   (PAGE_BITS),
		.SEG_BITS    (SEG_BITS),
		.FRAME_BITS  (FRAME_BITS),
		.NUM_PROCS   (NUM_PROCS),
		.SLOTS       (SLOTS),
		.ENT_W       (ENT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.q_valid   (qb_valid),
		.q_ready   (qb_ready),
		.q_data    (qb_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_data (read_data),
		.status    (status)
	);

endmodule

@@ rtl/core/tlpt_checker.sv @@
// tlpt_checker: port-level assertions for the translated memory core,
// bound to two_level_page_translate_mem_core; depends on tlpt_pkg
module tlpt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [tlpt_pkg::DATA_W-1:0] read_data,
	input logic                        status
);
	// transactions accepted but not yet delivered
	logic [2:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if ((in_valid && in_ready) && !(out_valid && out_ready)) begin
			pending_q <= pending_q + 3'd1;
		end else if (!(in_valid && in_ready) && (out_valid && out_ready)) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(status))
		else $error("result changed while stalled");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> read_data == '0)
		else $error("fault result carries nonzero data");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result without an outstanding transaction");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd4)
		else $error("more transactions in flight than the pipeline holds");

endmodule

bind two_level_page_translate_mem_core tlpt_checker u_tlpt_checker (.*);
